// ===== design/als_pkg.sv =====
`default_nettype none
package als_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int WORD_W    = 32;
    localparam int CAP_W     = 5;
    localparam int POS_W     = 5;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_DEPTH);

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_PEEK = 2'd2,
        KIND_NOP  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2,
        STATUS_BAD_POS   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        DSEL_ZERO,
        DSEL_MEM,
        DSEL_ERR
    } dsel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

endpackage
`default_nettype wire

// ===== design/als_ctrl.sv =====
`default_nettype none
module als_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output als_pkg::cmd_t    cmd
);
    import als_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
            end
            ST_RESP: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/als_dpath.sv =====
`default_nettype none
module als_dpath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire als_pkg::cmd_t                       cmd,
    input  wire logic                                cfg_we,
    input  wire logic [als_pkg::CAP_W-1:0]           cfg_data,
    input  wire logic [als_pkg::KIND_W-1:0]          in_kind,
    input  wire logic signed [als_pkg::WORD_W-1:0]   in_push_value,
    input  wire logic [als_pkg::POS_W-1:0]           in_peek_position,
    output logic signed [als_pkg::WORD_W-1:0]        out_read_data,
    output logic [als_pkg::STATUS_W-1:0]             out_status,
    output logic                                     out_is_empty,
    output logic                                     out_is_full
);
    import als_pkg::*;

    logic [WORD_W-1:0] mem [MAX_DEPTH];

    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    kind_t             kind_reg;
    logic [WORD_W-1:0] value_reg;
    logic [POS_W-1:0]  pos_reg;
    status_t           status_reg;
    status_t           status_next;
    dsel_t             dsel_reg;
    dsel_t             dsel_next;
    logic [WORD_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]  cap_use;
    logic [CNT_W-1:0]  pos_ext;
    logic [CNT_W-1:0]  rd_index;
    logic              wr_en;

    // clamp capacity into 1..MAX_DEPTH
    always_comb begin
        if (cap_reg == '0) begin
            cap_use = CNT_W'(1);
        end else if (CNT_W'(cap_reg) > CNT_W'(MAX_DEPTH)) begin
            cap_use = CNT_W'(MAX_DEPTH);
        end else begin
            cap_use = CNT_W'(cap_reg);
        end
    end

    assign pos_ext = CNT_W'(pos_reg);

    always_comb begin
        count_next  = count_reg;
        status_next = STATUS_OK;
        dsel_next   = DSEL_ZERO;
        rd_index    = count_reg - CNT_W'(1);
        wr_en       = 1'b0;
        case (kind_reg)
            KIND_PUSH: begin
                if (count_reg >= cap_use) begin
                    status_next = STATUS_OVERFLOW;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_POP: begin
                if (count_reg == '0) begin
                    status_next = STATUS_UNDERFLOW;
                    dsel_next   = DSEL_ERR;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    dsel_next  = DSEL_MEM;
                end
            end
            KIND_PEEK: begin
                rd_index = count_reg - pos_ext;
                if (pos_ext == '0 || pos_ext > count_reg) begin
                    status_next = STATUS_BAD_POS;
                    dsel_next   = DSEL_ERR;
                end else begin
                    dsel_next = DSEL_MEM;
                end
            end
            default: begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_data;
            end
            if (cmd.execute) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg  <= kind_t'(in_kind);
            value_reg <= in_push_value;
            pos_reg   <= in_peek_position;
        end
        if (cmd.execute) begin
            status_reg <= status_next;
            dsel_reg   <= dsel_next;
        end
    end

    // entry store
    always_ff @(posedge aclk) begin
        if (cmd.execute && wr_en) begin
            mem[count_reg[ADDR_W-1:0]] <= value_reg;
        end
        if (cmd.execute) begin
            rd_data_reg <= mem[rd_index[ADDR_W-1:0]];
        end
    end

    always_comb begin
        case (dsel_reg)
            DSEL_MEM:  out_read_data = rd_data_reg;
            DSEL_ERR:  out_read_data = '1;
            default:   out_read_data = '0;
        endcase
    end

    assign out_status   = status_reg;
    assign out_is_empty = (count_reg == '0);
    assign out_is_full  = (count_reg >= cap_use);

endmodule
`default_nettype wire

// ===== design/array_lifo_stack_core.sv =====
// after input accept the controller steps through execute, then respond, where the result is valid
// a new item is accepted only after the previous result is taken
// one item in flight; the entry store is read, and on a push also written, in the execute cycle
// reset: synchronous active-low aresetn empties the stack and sets capacity to 16
// entry store contents are not cleared by reset
`default_nettype none
module array_lifo_stack_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [als_pkg::KIND_W-1:0]          s_kind,
    input  wire logic signed [als_pkg::WORD_W-1:0]   s_push_value,
    input  wire logic [als_pkg::POS_W-1:0]           s_peek_position,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [als_pkg::WORD_W-1:0]        m_read_data,
    output logic [als_pkg::STATUS_W-1:0]             m_status,
    output logic                                     m_is_empty,
    output logic                                     m_is_full,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [als_pkg::CAP_W-1:0]           cfg_data
);
    import als_pkg::*;

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    als_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    als_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg_we           (cfg_valid),
        .cfg_data         (cfg_data),
        .in_kind          (s_kind),
        .in_push_value    (s_push_value),
        .in_peek_position (s_peek_position),
        .out_read_data    (m_read_data),
        .out_status       (m_status),
        .out_is_empty     (m_is_empty),
        .out_is_full      (m_is_full)
    );

endmodule
`default_nettype wire
